@@ src/okes_pkg.sv @@
// Shared types, constants and helper functions for the Euler-step orbit integrator.
package okes_pkg;

  localparam int FRAC_BITS_DEF = 24;
  localparam int WORD_W        = 32;
  localparam int STEP_W        = 31;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  typedef struct packed {
    logic               operation;
    logic signed [31:0] load_pos_x;
    logic signed [31:0] load_pos_y;
    logic signed [31:0] load_vel_x;
    logic signed [31:0] load_vel_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] orbit_energy;
    logic signed [31:0] angular_momentum;
    logic               singular;
  } out_item_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
    logic signed [31:0] r;
    if (v > 67'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -67'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Clamp an unsigned 64-bit value to 2^32-1.
  function automatic logic [31:0] cap32(input logic [63:0] v);
    logic [31:0] r;
    if (|v[63:32]) begin
      r = '1;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/okes_mul.sv @@
// Shared signed 33x33 multiplier with a registered product.
module okes_mul
  import okes_pkg::*;
(
  input  logic               clk,
  input  logic signed [32:0] a,
  input  logic signed [32:0] b,
  output logic signed [65:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

@@ src/okes_sqrt.sv @@
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle.
module okes_sqrt
  import okes_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] n;
  logic [63:0] res;
  logic [63:0] bitm;
  logic        busy;
  logic [63:0] trial;

  assign trial = res + bitm;
  assign root  = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n    <= radicand;
        res  <= '0;
        bitm <= 64'h4000_0000_0000_0000;
        busy <= 1'b1;
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitm;
        end else begin
          res <= res >> 1;
        end
        bitm <= bitm >> 2;
        if (bitm[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/okes_div.sv @@
// Restoring divider for 2^(2F) / r, one quotient bit per cycle, capped at 32 bits.
module okes_div
  import okes_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quotient
);

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam int IW = $clog2(QW);
  localparam logic [IW-1:0] TOP_IDX = IW'(QW - 1);

  logic [IW-1:0] idx;
  logic [31:0]   rem;
  logic [QW-1:0] q;
  logic          busy;
  logic [32:0]   rem_s;

  assign rem_s    = {rem, (idx == TOP_IDX)};
  assign quotient = (|q[QW-1:32]) ? '1 : q[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem  <= '0;
        q    <= '0;
        idx  <= TOP_IDX;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_s >= {1'b0, divisor}) begin
          rem <= 32'(rem_s - {1'b0, divisor});
          q   <= {q[QW-2:0], 1'b1};
        end else begin
          rem <= rem_s[31:0];
          q   <= {q[QW-2:0], 1'b0};
        end
        idx <= idx - 1'b1;
        if (idx == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ src/kepler_orbit_euler_step.sv @@
// A load item is taken in S_IDLE and leaves the block idle. A step item runs fourteen
// products on one shared multiplier, each through S_MUL and S_WB: first the report
// products, then the bit-serial square root, the restoring divider, the loading of the
// result and the update products; a zero radius skips the divider and the update. No
// new item is taken until the step ends; a result waits until an earlier one is taken.
// Synchronous reset restores x = 1, y = 0, vx = 0, vy = 1, the timestep 0.3 and no result.
module kepler_orbit_euler_step
  import okes_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_item,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [STEP_W-1:0] cfg_data
);

  // Fixed-point one and the reset timestep 0.3, rounded to nearest.
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;
  localparam longint STEP_RST_L = (3 * (longint'(1) << FRAC_BITS) + 5) / 10;
  localparam logic [STEP_W-1:0] STEP_RST = STEP_W'(STEP_RST_L);

  // Sequencer states: the multiplier is issued in S_MUL and its product is
  // consumed in S_WB.
  typedef enum logic [2:0] {S_IDLE, S_MUL, S_WB, S_SQRT, S_DIV, S_OUT} state_t;

  // Products in the order they are taken. The first six feed the report,
  // the rest form the Euler update from the old state.
  typedef enum logic [3:0] {
    M_XX, M_YY, M_XVY, M_YVX, M_VXVX, M_VYVY,
    M_IR2, M_IR3, M_AX, M_AY, M_PX, M_PY, M_VX, M_VY
  } mop_t;

  state_t st;
  mop_t   op;

  logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
  logic [STEP_W-1:0]  step_size;

  logic [63:0]        r2, kin;
  logic signed [65:0] ang_acc;
  logic signed [31:0] ang_res, energy, acc_x, acc_y;
  logic [31:0]        inv_r, inv_r2, inv_r3;
  logic               sing;
  logic               sqrt_start, div_start;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod;
  logic signed [66:0] prod_w, prod_sh;
  logic [63:0]        prod_u_sh;
  logic               sqrt_done, div_done;
  logic [31:0]        root, quot;
  logic signed [66:0] energy_w;

  assign in_ready  = (st == S_IDLE);
  assign cfg_ready = 1'b1;

  okes_mul u_mul (.clk(clk), .a(opa), .b(opb), .p(prod));

  okes_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .radicand(r2),
    .done(sqrt_done), .root(root)
  );

  okes_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .divisor(root),
    .done(div_done), .quotient(quot)
  );

  // Operand selection. Unsigned quantities (inverse powers of r and the
  // timestep) are zero extended so that one signed multiplier serves all.
  always_comb begin
    unique case (op)
      M_XX:    begin opa = 33'(pos_x); opb = 33'(pos_x); end
      M_YY:    begin opa = 33'(pos_y); opb = 33'(pos_y); end
      M_XVY:   begin opa = 33'(pos_x); opb = 33'(vel_y); end
      M_YVX:   begin opa = 33'(pos_y); opb = 33'(vel_x); end
      M_VXVX:  begin opa = 33'(vel_x); opb = 33'(vel_x); end
      M_VYVY:  begin opa = 33'(vel_y); opb = 33'(vel_y); end
      M_IR2:   begin opa = $signed({1'b0, inv_r});  opb = $signed({1'b0, inv_r}); end
      M_IR3:   begin opa = $signed({1'b0, inv_r2}); opb = $signed({1'b0, inv_r}); end
      M_AX:    begin opa = 33'(pos_x); opb = $signed({1'b0, inv_r3}); end
      M_AY:    begin opa = 33'(pos_y); opb = $signed({1'b0, inv_r3}); end
      M_PX:    begin opa = 33'(vel_x); opb = $signed({2'b0, step_size}); end
      M_PY:    begin opa = 33'(vel_y); opb = $signed({2'b0, step_size}); end
      M_VX:    begin opa = 33'(acc_x); opb = $signed({2'b0, step_size}); end
      default: begin opa = 33'(acc_y); opb = $signed({2'b0, step_size}); end
    endcase
  end

  // Shifted forms of the product; the arithmetic shift rounds toward minus infinity.
  assign prod_w    = {prod[65], prod};
  assign prod_sh   = prod_w >>> FRAC_BITS;
  assign prod_u_sh = prod[63:0] >> FRAC_BITS;

  // Energy: kinetic part is truncated by F+1 bits, then the inverse radius is taken off.
  assign energy_w = $signed({3'b0, kin >> (FRAC_BITS + 1)}) - $signed({35'b0, quot});

  always_ff @(posedge clk) begin
    if (rst) begin
      st         <= S_IDLE;
      op         <= M_XX;
      out_valid  <= 1'b0;
      sqrt_start <= 1'b0;
      div_start  <= 1'b0;
      step_size  <= STEP_RST;
      pos_x      <= ONE;
      pos_y      <= '0;
      vel_x      <= '0;
      vel_y      <= ONE;
    end else begin
      sqrt_start <= 1'b0;
      div_start  <= 1'b0;
      if (cfg_valid) begin
        step_size <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            if (in_item.operation == OP_LOAD) begin
              pos_x <= in_item.load_pos_x;
              pos_y <= in_item.load_pos_y;
              vel_x <= in_item.load_vel_x;
              vel_y <= in_item.load_vel_y;
            end else begin
              op <= M_XX;
              st <= S_MUL;
            end
          end
        end
        S_MUL: st <= S_WB;
        S_WB: begin
          st <= S_MUL;
          op <= mop_t'(op + 1'b1);
          unique case (op)
            M_XX:   r2 <= prod[63:0];
            M_YY:   r2 <= r2 + prod[63:0];
            M_XVY:  ang_acc <= prod;
            M_YVX:  ang_res <= sat32(($signed({ang_acc[65], ang_acc}) - prod_w) >>> FRAC_BITS);
            M_VXVX: kin <= prod[63:0];
            M_VYVY: begin
              // Report products done: hand the squared radius to the square root.
              kin        <= kin + prod[63:0];
              sqrt_start <= 1'b1;
              st         <= S_SQRT;
            end
            M_IR2:  inv_r2 <= cap32(prod_u_sh);
            M_IR3:  inv_r3 <= cap32(prod_u_sh);
            M_AX:   acc_x <= sat32((-prod_w) >>> FRAC_BITS);
            M_AY:   acc_y <= sat32((-prod_w) >>> FRAC_BITS);
            M_PX:   pos_x <= sat32(67'(pos_x) + prod_sh);
            M_PY:   pos_y <= sat32(67'(pos_y) + prod_sh);
            M_VX:   vel_x <= sat32(67'(vel_x) + prod_sh);
            default: begin
              vel_y <= sat32(67'(vel_y) + prod_sh);
              st    <= S_IDLE;
            end
          endcase
        end
        S_SQRT: begin
          if (sqrt_done) begin
            if (root == '0) begin
              // Body at the origin: no inverse radius, state stays as it is.
              sing   <= 1'b1;
              energy <= 32'sh80000000;
              st     <= S_OUT;
            end else begin
              sing      <= 1'b0;
              div_start <= 1'b1;
              st        <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            inv_r  <= quot;
            energy <= sat32(energy_w);
            st     <= S_OUT;
          end
        end
        default: begin
          // Load the result register once any earlier result has been taken.
          if (!out_valid || out_ready) begin
            out_valid                 <= 1'b1;
            out_item.out_pos_x        <= pos_x;
            out_item.out_pos_y        <= pos_y;
            out_item.orbit_energy     <= energy;
            out_item.angular_momentum <= ang_res;
            out_item.singular         <= sing;
            if (sing) begin
              st <= S_IDLE;
            end else begin
              op <= M_IR2;
              st <= S_MUL;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ src/okes_check.sv @@
// Port-level assertions for the orbit integrator and their binding to the top level.
module okes_check
  import okes_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result item changed or vanished while stalled");

  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_sing_energy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.singular |-> out_item.orbit_energy == 32'sh80000000)
    else $error("singular result without most negative energy");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.operation == OP_LOAD && !out_valid |=> !out_valid)
    else $error("load item produced a result");

  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_item.operation == OP_STEP |=> !in_ready)
    else $error("step item did not occupy the block");

endmodule

bind kepler_orbit_euler_step okes_check u_okes_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
  .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
);

@@ verif/kepler_orbit_euler_step_test.sv @@
// Self-checking testbench for the Euler-step two-body orbit integrator.
module kepler_orbit_euler_step_test;
  import okes_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  // Cycles with no accepted item before the run is declared hung; the limit covers
  // a step in flight and the longest deliberate receiver hold-off.
  localparam int HANG_LIMIT = 3000;
  // Quiet cycles allowed after the last result, covering one step in flight.
  localparam int DRAIN_CYCLES = 150;
  localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q = 32'sh01000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [STEP_W-1:0] cfg_data = '0;

  kepler_orbit_euler_step i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the orbit state and the timestep register.
  logic signed [31:0] orb_x, orb_y, orb_vx, orb_vy;
  logic [STEP_W-1:0]  orb_dt;

  out_item_t pending_reports[$];
  int errors = 0;
  int loads_sent = 0;
  int steps_sent = 0;
  int reports_seen = 0;
  int singular_seen = 0;
  int burst_left = 0;
  int hold_len = 0;
  int quiet_cycles = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
    if (v > 128'sd2147483647) return S32_MAX;
    if (v < -128'sd2147483648) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] cap_u32(input logic signed [127:0] v);
    return (v > 128'sd4294967295) ? 128'sd4294967295 : v;
  endfunction

  // Floor square root of a 64-bit unsigned value, digit by digit.
  function automatic logic [63:0] floor_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Applies one item to the predicted state; a step also yields the report
  // that the block must produce. All math is done wide, then clamped.
  task automatic advance_orbit(input in_item_t it, output bit has_report,
                               output out_item_t rep);
    logic signed [127:0] x, y, vx, vy, dt, r2, rad, ir, ir2, ir3, kin, ax, ay;
    x = orb_x;
    y = orb_y;
    vx = orb_vx;
    vy = orb_vy;
    dt = $signed({97'd0, orb_dt});
    rep = '0;
    has_report = 1'b0;
    if (it.operation == OP_LOAD) begin
      orb_x = it.load_pos_x;
      orb_y = it.load_pos_y;
      orb_vx = it.load_vel_x;
      orb_vy = it.load_vel_y;
    end else begin
      has_report = 1'b1;
      r2 = x * x + y * y;
      rad = $signed({64'd0, floor_sqrt(r2[63:0])});
      kin = (vx * vx + vy * vy) >>> (FB + 1);
      rep.out_pos_x = orb_x;
      rep.out_pos_y = orb_y;
      rep.angular_momentum = clamp32((x * vy - y * vx) >>> FB);
      if (rad == 0) begin
        // Body sits on the central mass: flag it and keep the state.
        rep.singular = 1'b1;
        rep.orbit_energy = S32_MIN;
      end else begin
        ir = cap_u32((128'sd1 <<< (2 * FB)) / rad);
        ir2 = cap_u32((ir * ir) >>> FB);
        ir3 = cap_u32((ir2 * ir) >>> FB);
        rep.orbit_energy = clamp32(kin - ir);
        ax = clamp32((-(x * ir3)) >>> FB);
        ay = clamp32((-(y * ir3)) >>> FB);
        // Every update is taken from the old state.
        orb_x = clamp32(x + ((vx * dt) >>> FB));
        orb_y = clamp32(y + ((vy * dt) >>> FB));
        orb_vx = clamp32(vx + ((ax * dt) >>> FB));
        orb_vy = clamp32(vy + ((ay * dt) >>> FB));
      end
    end
  endtask

  // Offers one item, keeping valid high across items inside a burst; this task
  // drops valid only for the gaps between bursts.
  task automatic send_item(input in_item_t it);
    bit has_report;
    out_item_t rep;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(6, 0);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(30, 1);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    burst_left--;
    advance_orbit(it, has_report, rep);
    if (has_report) begin
      pending_reports.push_back(rep);
      steps_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  task automatic send_load(input logic signed [31:0] px, input logic signed [31:0] py,
                           input logic signed [31:0] vx, input logic signed [31:0] vy);
    in_item_t it;
    it.operation = OP_LOAD;
    it.load_pos_x = px;
    it.load_pos_y = py;
    it.load_vel_x = vx;
    it.load_vel_y = vy;
    send_item(it);
  endtask

  // A step item carries random load fields, which the block must ignore.
  task automatic send_step();
    in_item_t it;
    it.operation = OP_STEP;
    it.load_pos_x = $urandom;
    it.load_pos_y = $urandom;
    it.load_vel_x = $urandom;
    it.load_vel_y = $urandom;
    send_item(it);
  endtask

  // The timestep is only changed with the block idle: every report is back
  // and a trailing load has had time to settle.
  task automatic write_step_size(input logic [STEP_W-1:0] value);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    orb_dt = value;
  endtask

  // Q8.24 value drawn from [-lim, lim] where lim is given in whole units.
  function automatic logic signed [31:0] rand_q(input int lim_units);
    int span;
    span = lim_units << FB;
    return int'($urandom_range(2 * span, 0)) - span;
  endfunction

  // The reset orbit is a unit circle; step it a few times from reset.
  task automatic test_reset_orbit();
    repeat (4) send_step();
  endtask

  // Corners of the fields and the special cases: zero radius, radius of one
  // LSB (inverse powers cap), saturating positions and velocities.
  task automatic test_field_extremes();
    send_load(0, 0, ONE_Q, -ONE_Q);
    send_step();
    send_step();
    send_load(1, 0, 0, 0);
    send_step();
    send_step();
    send_load(S32_MAX, S32_MAX, S32_MAX, S32_MAX);
    send_step();
    send_step();
    send_load(S32_MIN, S32_MIN, S32_MIN, S32_MIN);
    send_step();
    send_step();
    send_load(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
    send_step();
    send_load(32'sh55555555, 32'shAAAAAAAA, 32'shAAAAAAAA, 32'sh55555555);
    send_step();
    send_load(-1, -1, -1, -1);
    send_step();
    send_load(0, -ONE_Q, -ONE_Q, 0);
    send_step();
  endtask

  // Zero timestep freezes the orbit, the largest one saturates it.
  task automatic test_step_sizes();
    write_step_size('0);
    send_load(ONE_Q, ONE_Q, -ONE_Q, ONE_Q);
    repeat (3) send_step();
    write_step_size('1);
    send_load(ONE_Q, 0, 0, ONE_Q);
    repeat (4) send_step();
    write_step_size(31'd5033165);
  endtask

  // Mostly well-formed orbits (a load followed by a run of steps), with some
  // noise items carrying full-range random fields.
  task automatic test_random_orbits(input int n_items);
    int sent;
    int run;
    in_item_t it;
    sent = 0;
    while (sent < n_items) begin
      if (sent > 0 && sent % 200 == 0) write_step_size(STEP_W'($urandom_range(16777216, 1)));
      if ($urandom_range(9, 0) == 0) begin
        it.operation = 1'($urandom_range(1, 0));
        it.load_pos_x = $urandom;
        it.load_pos_y = $urandom;
        it.load_vel_x = $urandom;
        it.load_vel_y = $urandom;
        send_item(it);
        sent++;
      end else begin
        send_load(rand_q(4), rand_q(4), rand_q(2), rand_q(2));
        run = $urandom_range(30, 5);
        repeat (run) send_step();
        sent += run + 1;
      end
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  // steps, so the single item in work backs up into the input.
  task automatic test_backpressure();
    hold_len = 400;
    repeat (12) send_step();
  endtask

  // Receiver stall pattern: open stretches alternate with random stalls, and
  // a requested hold-off keeps it closed for that many cycles.
  logic [7:0] stall_phase = '0;
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1'b1;
    if (hold_len > 0) begin
      hold_len <= hold_len - 1;
      out_ready <= 1'b0;
    end else if (stall_phase[6]) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(3, 0) != 0);
    end
  end

  // Compares every accepted report with the oldest expected one.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: report with none expected, actual %h", $time, out_item);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (out_item.singular) singular_seen++;
        if (out_item.out_pos_x !== want.out_pos_x) begin
          $display("%0t: out_pos_x expected %h actual %h", $time, want.out_pos_x,
                   out_item.out_pos_x);
          errors++;
        end
        if (out_item.out_pos_y !== want.out_pos_y) begin
          $display("%0t: out_pos_y expected %h actual %h", $time, want.out_pos_y,
                   out_item.out_pos_y);
          errors++;
        end
        if (out_item.orbit_energy !== want.orbit_energy) begin
          $display("%0t: orbit_energy expected %h actual %h", $time, want.orbit_energy,
                   out_item.orbit_energy);
          errors++;
        end
        if (out_item.angular_momentum !== want.angular_momentum) begin
          $display("%0t: angular_momentum expected %h actual %h", $time,
                   want.angular_momentum, out_item.angular_momentum);
          errors++;
        end
        if (out_item.singular !== want.singular) begin
          $display("%0t: singular expected %b actual %b", $time, want.singular,
                   out_item.singular);
          errors++;
        end
      end
    end
  end

  // Hang detector: counts cycles in which no channel moves an item.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("kepler_orbit_euler_step test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    orb_x = ONE_Q;
    orb_y = 0;
    orb_vx = 0;
    orb_vy = ONE_Q;
    orb_dt = 31'd5033165;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_orbit();
    test_field_extremes();
    test_step_sizes();
    test_backpressure();
    test_random_orbits(800);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d loads and %0d steps, %0d reports checked (%0d singular),",
             loads_sent, steps_sent, reports_seen, singular_seen);
    $display("across timesteps of zero, the maximum, the default and random values.");
    if (errors == 0 && pending_reports.size() == 0) begin
      $display("kepler_orbit_euler_step test passed");
    end else begin
      $display("kepler_orbit_euler_step test failed");
    end
    $finish;
  end

endmodule
